/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the sender block. Both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every edge outside reset
`define GBNFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gbnfr assertion failed");
// antecedent implies consequent in the same cycle
`define GBNFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbnfr implication failed");
`else
`define GBNFR_ASSERT(lbl, prop)
`define GBNFR_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

/* src/gbnfr_pkg.sv */
// ----------------------------------------------------------------------------
// gbnfr_pkg
// Shared types and codes of the go-back-N sender: opcodes, timer commands,
// register indexes, the packet word and the queue word.
// ----------------------------------------------------------------------------
package gbnfr_pkg;

  localparam int CFG_W  = 3;
  localparam int SEQ_W  = 3;
  localparam int LOW_W  = 64;
  localparam int MID_W  = 64;
  localparam int HIGH_W = 40;
  localparam int CHK_W  = 16;

  // input opcodes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // timer commands
  localparam logic [1:0] TMR_LEAVE   = 2'd0;
  localparam logic [1:0] TMR_RESTART = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;

  // configuration register indexes
  localparam logic REG_WINDOW_SIZE   = 1'b0;
  localparam logic REG_DUP_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST   = 3'd4;
  localparam logic [CFG_W-1:0] DUP_THRESHOLD_RST = 3'd3;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_ACK     = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [LOW_W-1:0]  low;
    logic [MID_W-1:0]  mid;
    logic [HIGH_W-1:0] high;
    logic [CHK_W-1:0]  chk;
  } pkt_t;

  typedef struct packed {
    cmd_t             cmd;
    pkt_t             pkt;
    logic [SEQ_W-1:0] ack_number;
    logic             ack_in_range;
  } qent_t;

endpackage

/* src/gbnfr_front.sv */
// ----------------------------------------------------------------------------
// gbnfr_front
// Takes input words, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gbnfr_front #(
  parameter int SEQ_SPACE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [gbnfr_pkg::LOW_W-1:0]   in_payload_low,
  input  logic [gbnfr_pkg::MID_W-1:0]   in_payload_mid,
  input  logic [gbnfr_pkg::HIGH_W-1:0]  in_payload_high,
  input  logic [gbnfr_pkg::CHK_W-1:0]   in_data_checksum,
  input  logic [gbnfr_pkg::SEQ_W-1:0]   in_ack_number,
  input  logic                          in_ack_checksum_ok,
  output logic                          q_valid,
  input  logic                          q_ready,
  output gbnfr_pkg::qent_t              q_data
);
  import gbnfr_pkg::*;

  qent_t       ent;
  qent_t       qe_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push, pop;

  // classify the incoming word
  always_comb begin
    ent              = '0;
    ent.pkt.low      = in_payload_low;
    ent.pkt.mid      = in_payload_mid;
    ent.pkt.high     = in_payload_high;
    ent.pkt.chk      = in_data_checksum;
    ent.ack_number   = in_ack_number;
    ent.ack_in_range = ({29'd0, in_ack_number} < 32'(SEQ_SPACE));
    case (in_op)
      OP_SEND:    ent.cmd = CMD_SEND;
      OP_ACK:     ent.cmd = in_ack_checksum_ok ? CMD_ACK : CMD_NONE;
      OP_TIMEOUT: ent.cmd = CMD_TIMEOUT;
      default:    ent.cmd = CMD_NONE;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = qe_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qe_r[wr_ptr_r] <= ent;
    end
  end

endmodule

/* src/gbnfr_back.sv */
// ----------------------------------------------------------------------------
// gbnfr_back
// Executes queued commands against the window pointers and packet store, and
// holds each result in an output stage until it is taken.
// ----------------------------------------------------------------------------
module gbnfr_back #(
  parameter int SEQ_SPACE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  gbnfr_pkg::qent_t              q_data,
  input  logic [gbnfr_pkg::CFG_W-1:0]   window_size,
  input  logic [gbnfr_pkg::CFG_W-1:0]   dup_threshold,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_send_accepted,
  output logic                          out_window_full,
  output logic                          out_packet_valid,
  output logic [gbnfr_pkg::SEQ_W-1:0]   out_packet_seq,
  output logic [gbnfr_pkg::LOW_W-1:0]   out_packet_payload_low,
  output logic [gbnfr_pkg::MID_W-1:0]   out_packet_payload_mid,
  output logic [gbnfr_pkg::HIGH_W-1:0]  out_packet_payload_high,
  output logic [gbnfr_pkg::CHK_W-1:0]   out_packet_checksum,
  output logic [1:0]                    out_timer_command
);
  import gbnfr_pkg::*;

  localparam int PW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;
  localparam logic [PW:0]   SPACE = (PW+1)'(SEQ_SPACE);
  localparam logic [PW-1:0] LAST  = PW'(SEQ_SPACE - 1);
  localparam logic [CW-1:0] WMAX  = CW'(SEQ_SPACE - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  // (a - b) modulo the sequence space
  function automatic logic [PW-1:0] ptr_diff(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) t = t + SPACE;
    return t[PW-1:0];
  endfunction

  // window state
  logic [PW-1:0]    base_r, base_nxt;
  logic [PW-1:0]    next_r, next_nxt;
  logic [CFG_W-1:0] dup_r, dup_nxt;

  // output stage
  logic             a_valid_r;
  logic             acc_r, full_r, pv_r, fs_r;
  logic [PW-1:0]    seq_r;
  logic [1:0]       tmr_r;
  pkt_t             item_r;
  pkt_t             rd_r;

  // packet store
  pkt_t             mem [SEQ_SPACE];

  logic             advance;
  logic [CW-1:0]    win_eff;
  logic [PW-1:0]    cnt, ack_p, off, ack_inc;
  logic [CFG_W-1:0] dup_inc;
  logic             in_win;
  logic             mem_we;
  logic             acc, full, pv, fs;
  logic [PW-1:0]    seq;
  logic [1:0]       tmr;
  pkt_t             emit;

  assign q_ready = !a_valid_r || out_ready;
  assign advance = q_valid && q_ready;

  // execute one command
  always_comb begin
    win_eff  = (CW'(window_size) > WMAX) ? WMAX : CW'(window_size);
    cnt      = ptr_diff(next_r, base_r);
    ack_p    = PW'(q_data.ack_number);
    off      = ptr_diff(ack_p, base_r);
    ack_inc  = ptr_inc(ack_p);
    in_win   = q_data.ack_in_range && (off < cnt);
    dup_inc  = dup_r + 1'b1;
    base_nxt = base_r;
    next_nxt = next_r;
    dup_nxt  = dup_r;
    mem_we   = 1'b0;
    acc      = 1'b0;
    pv       = 1'b0;
    fs       = 1'b0;
    seq      = '0;
    tmr      = TMR_LEAVE;
    case (q_data.cmd)
      CMD_SEND: begin
        if (CW'(cnt) < win_eff) begin
          mem_we   = 1'b1;
          acc      = 1'b1;
          pv       = 1'b1;
          seq      = next_r;
          tmr      = (base_r == next_r) ? TMR_RESTART : TMR_LEAVE;
          next_nxt = ptr_inc(next_r);
        end
      end
      CMD_ACK: begin
        if (cnt != '0) begin
          if (in_win) begin
            base_nxt = ack_inc;
            dup_nxt  = '0;
            tmr      = (ack_inc == next_r) ? TMR_STOP : TMR_RESTART;
          end else if (dup_inc >= dup_threshold) begin
            pv      = 1'b1;
            fs      = 1'b1;
            seq     = base_r;
            tmr     = TMR_RESTART;
            dup_nxt = '0;
          end else begin
            dup_nxt = dup_inc;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (base_r != next_r) begin
          pv  = 1'b1;
          fs  = 1'b1;
          seq = base_r;
          tmr = TMR_RESTART;
        end else begin
          tmr = TMR_STOP;
        end
      end
      default: begin
      end
    endcase
    full = (CW'(ptr_diff(next_nxt, base_nxt)) >= win_eff);
  end

  // state and output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      next_r    <= '0;
      dup_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (q_ready) begin
        a_valid_r <= q_valid;
      end
      if (advance) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        dup_r  <= dup_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      acc_r  <= acc;
      full_r <= full;
      pv_r   <= pv;
      fs_r   <= fs;
      seq_r  <= seq;
      tmr_r  <= tmr;
      item_r <= q_data.pkt;
    end
  end

  // store write at next_seq, resend read at base
  always_ff @(posedge clk) begin
    if (advance && mem_we) begin
      mem[next_r] <= q_data.pkt;
    end
    if (advance && fs) begin
      rd_r <= mem[base_r];
    end
  end

  // drive the result word
  always_comb begin
    emit = '0;
    if (pv_r) begin
      emit = fs_r ? rd_r : item_r;
    end
  end

  assign out_valid               = a_valid_r;
  assign out_send_accepted       = acc_r;
  assign out_window_full         = full_r;
  assign out_packet_valid        = pv_r;
  assign out_packet_seq          = SEQ_W'(seq_r);
  assign out_packet_payload_low  = emit.low;
  assign out_packet_payload_mid  = emit.mid;
  assign out_packet_payload_high = emit.high;
  assign out_packet_checksum     = emit.chk;
  assign out_timer_command       = tmr_r;

endmodule

/* src/go_back_n_sender_fast_retransmit.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_fast_retransmit
// Go-back-N ARQ sender with one timer and duplicate-ack fast retransmit.
// ----------------------------------------------------------------------------
// One word is taken per clock while the receiver keeps taking results, and
// every word gives exactly one result word. A taken word is registered in the
// front classify queue, then the back end updates base, next sequence number
// and duplicate count and registers the result, which sets the rate of one
// word per cycle. While the receiver holds off, up to three words are held
// (two queued, one result) before the input stalls. The packet store holds
// SEQ_SPACE entries, is not cleared at reset, and only outstanding entries
// are ever resent.
// Configuration writes are always taken (cfg_ready is tied high) and should
// come while no word is in flight.
module go_back_n_sender_fast_retransmit #(
  parameter int SEQ_SPACE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [gbnfr_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [gbnfr_pkg::LOW_W-1:0]   in_payload_low,
  input  logic [gbnfr_pkg::MID_W-1:0]   in_payload_mid,
  input  logic [gbnfr_pkg::HIGH_W-1:0]  in_payload_high,
  input  logic [gbnfr_pkg::CHK_W-1:0]   in_data_checksum,
  input  logic [gbnfr_pkg::SEQ_W-1:0]   in_ack_number,
  input  logic                          in_ack_checksum_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_send_accepted,
  output logic                          out_window_full,
  output logic                          out_packet_valid,
  output logic [gbnfr_pkg::SEQ_W-1:0]   out_packet_seq,
  output logic [gbnfr_pkg::LOW_W-1:0]   out_packet_payload_low,
  output logic [gbnfr_pkg::MID_W-1:0]   out_packet_payload_mid,
  output logic [gbnfr_pkg::HIGH_W-1:0]  out_packet_payload_high,
  output logic [gbnfr_pkg::CHK_W-1:0]   out_packet_checksum,
  output logic [1:0]                    out_timer_command
);
  import gbnfr_pkg::*;

`include "assert_macros.svh"

  logic [CFG_W-1:0] window_size_r, window_size_nxt;
  logic [CFG_W-1:0] dup_threshold_r, dup_threshold_nxt;
  logic             q_valid, q_ready;
  qent_t            q_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    window_size_nxt   = window_size_r;
    dup_threshold_nxt = dup_threshold_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_SIZE:   window_size_nxt   = cfg_data;
        REG_DUP_THRESHOLD: dup_threshold_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WINDOW_SIZE_RST;
      dup_threshold_r <= DUP_THRESHOLD_RST;
    end else begin
      window_size_r   <= window_size_nxt;
      dup_threshold_r <= dup_threshold_nxt;
    end
  end

  gbnfr_front #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_payload_low     (in_payload_low),
    .in_payload_mid     (in_payload_mid),
    .in_payload_high    (in_payload_high),
    .in_data_checksum   (in_data_checksum),
    .in_ack_number      (in_ack_number),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_data             (q_data)
  );

  gbnfr_back #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_valid                 (q_valid),
    .q_ready                 (q_ready),
    .q_data                  (q_data),
    .window_size             (window_size_r),
    .dup_threshold           (dup_threshold_r),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_send_accepted       (out_send_accepted),
    .out_window_full         (out_window_full),
    .out_packet_valid        (out_packet_valid),
    .out_packet_seq          (out_packet_seq),
    .out_packet_payload_low  (out_packet_payload_low),
    .out_packet_payload_mid  (out_packet_payload_mid),
    .out_packet_payload_high (out_packet_payload_high),
    .out_packet_checksum     (out_packet_checksum),
    .out_timer_command       (out_timer_command)
  );

  // a full queue means the back end is holding a stalled result
  `GBNFR_ASSERT_IMP(a_full_queue_has_result, !in_ready, out_valid)
  // an accepted send always emits and never stops the timer
  `GBNFR_ASSERT_IMP(a_send_emits, out_valid && out_send_accepted,
                    out_packet_valid && out_timer_command != TMR_STOP)
  // stopping the timer means the window is empty: nothing is sent
  `GBNFR_ASSERT_IMP(a_stop_no_packet, out_valid && out_timer_command == TMR_STOP,
                    !out_packet_valid && !out_send_accepted)

endmodule
